### design/assert_macros.svh
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds at an edge, so the consequent holds at the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Antecedent holds at an edge, so the consequent holds at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### design/rsch_pkg.sv
// Package: types and constants of the reliable sequencing channel header block.
`timescale 1ns / 1ps
package rsch_pkg;

   localparam int MAX_PAYLOAD = 8192;
   localparam int HDR_BYTES   = 8;
   localparam int PORT_BYTES  = 2;
   localparam int MAX_SIZE    = MAX_PAYLOAD + HDR_BYTES;

   localparam int SEQ_W   = 31;
   localparam int WORD_W  = 32;
   localparam int LEN_W   = 14;
   localparam int BYTES_W = 15;
   // Wide enough to hold MAX_SIZE for any payload limit up to 64 KiB
   localparam int SIZE_W  = 17;
   localparam int FRAC_W  = 16;
   // Choke product: a full word above the dropped fraction bits
   localparam int PROD_W  = FRAC_W + WORD_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_CLIENT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIENT_PORT = 2'd2;

   localparam logic [WORD_W-1:0] RATE_RESET = 32'd26214;

   typedef enum logic {
      CMD_TRANSMIT = 1'b0,
      CMD_RECEIVE  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [WORD_W-1:0] now_ms;
      logic [LEN_W-1:0]  pending_length;
      logic              pending_overflowed;
      logic [LEN_W-1:0]  unreliable_length;
      logic [WORD_W-1:0] rx_seq_word;
      logic [WORD_W-1:0] rx_ack_word;
   } request_type;

   typedef struct packed {
      logic [WORD_W-1:0]  hdr_word_one;
      logic [WORD_W-1:0]  hdr_word_two;
      logic               packet_sent;
      logic               reliable_included;
      logic               pending_taken;
      logic               unreliable_included;
      logic [BYTES_W-1:0] packet_bytes;
      logic               channel_drop;
      logic               rx_accepted;
      logic               can_packet;
      logic               can_reliable;
   } result_type;

endpackage

### design/reliable_seq_channel_header_top.sv
// Top level: reliable sequencing core of a datagram channel header path.
// Structure: an accepted item is held in the input register, and its result
// is registered in the result register that drives the rsp_ port.
// Throughput: one item per cycle unless the consumer stalls; the whole transmit
// or receive step, with its single 15x32 choke multiply, fits between the registers.
// Reset (synchronous, active high) clears all sequence state, the choke
// time and both valid flags, and returns the rate to 0.4 ms/byte in Q16.
`timescale 1ns / 1ps
module reliable_seq_channel_header_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [rsch_pkg::WORD_W-1:0]         req_now_ms,
   input  logic [rsch_pkg::LEN_W-1:0]          req_pending_length,
   input  logic                                req_pending_overflowed,
   input  logic [rsch_pkg::LEN_W-1:0]          req_unreliable_length,
   input  logic [rsch_pkg::WORD_W-1:0]         req_rx_seq_word,
   input  logic [rsch_pkg::WORD_W-1:0]         req_rx_ack_word,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rsch_pkg::WORD_W-1:0]         rsp_hdr_word_one,
   output logic [rsch_pkg::WORD_W-1:0]         rsp_hdr_word_two,
   output logic                                rsp_packet_sent,
   output logic                                rsp_reliable_included,
   output logic                                rsp_pending_taken,
   output logic                                rsp_unreliable_included,
   output logic [rsch_pkg::BYTES_W-1:0]        rsp_packet_bytes,
   output logic                                rsp_channel_drop,
   output logic                                rsp_rx_accepted,
   output logic                                rsp_can_packet,
   output logic                                rsp_can_reliable,
   // configuration write port
   input  logic                                csr_we,
   input  logic [rsch_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsch_pkg::WORD_W-1:0]         csr_wdata
);
   import rsch_pkg::*;

   // configuration
   logic [WORD_W-1:0]  rate_ff;
   logic               is_client_ff;

   // channel state
   logic [SEQ_W-1:0]   out_seq_ff,      out_seq_in;
   logic [SEQ_W-1:0]   in_seq_ff,       in_seq_in;
   logic [SEQ_W-1:0]   in_ack_ff,       in_ack_in;
   logic               in_rel_acked_ff, in_rel_acked_in;
   logic               in_rel_bit_ff,   in_rel_bit_in;
   logic               out_rel_bit_ff,  out_rel_bit_in;
   logic [SEQ_W-1:0]   last_rel_seq_ff, last_rel_seq_in;
   logic [LEN_W-1:0]   rel_bytes_ff,    rel_bytes_in;
   logic [WORD_W-1:0]  choke_ff,        choke_in;

   // input register and result register
   logic               stage_valid_ff;
   request_type        stage_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff;
   result_type         result_in;

   logic               advance;
   logic               req_fire;

   // The input register moves on whenever the result register is free or
   // being emptied this cycle; a stalled result never blocks a held item
   // from staying put, and a new item enters once the stage frees up.
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // Configuration writes; the client port id affects only header length,
   // which is_client already covers, so its value is not kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= RATE_RESET;
         is_client_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE:        rate_ff      <= csr_wdata;
            CSR_IS_CLIENT:   is_client_ff <= csr_wdata[0];
            CSR_CLIENT_PORT: ;
            default:         ;
         endcase
      end
   end

   // Capture an item into the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff.cmd                <= cmd_type'(req_cmd);
         stage_ff.now_ms             <= req_now_ms;
         stage_ff.pending_length     <= req_pending_length;
         stage_ff.pending_overflowed <= req_pending_overflowed;
         stage_ff.unreliable_length  <= req_unreliable_length;
         stage_ff.rx_seq_word        <= req_rx_seq_word;
         stage_ff.rx_ack_word        <= req_rx_ack_word;
      end
   end

   // One pass over the held item: next state and the result item.
   always_comb begin
      logic               send_rel;
      logic               taken;
      logic               uinc;
      logic [SIZE_W-1:0]  size;
      logic [SIZE_W-1:0]  room;
      logic [BYTES_W-1:0] bytes;
      logic [PROD_W-1:0]  prod;
      logic [WORD_W-1:0]  delta;
      logic [SEQ_W-1:0]   rx_seq;

      out_seq_in      = out_seq_ff;
      in_seq_in       = in_seq_ff;
      in_ack_in       = in_ack_ff;
      in_rel_acked_in = in_rel_acked_ff;
      in_rel_bit_in   = in_rel_bit_ff;
      out_rel_bit_in  = out_rel_bit_ff;
      last_rel_seq_in = last_rel_seq_ff;
      rel_bytes_in    = rel_bytes_ff;
      choke_in        = choke_ff;
      result_in       = '0;

      send_rel = 1'b0;
      taken    = 1'b0;
      uinc     = 1'b0;
      size     = '0;
      room     = '0;
      bytes    = '0;
      prod     = '0;
      delta    = '0;
      rx_seq   = stage_ff.rx_seq_word[SEQ_W-1:0];

      if (stage_ff.cmd == CMD_TRANSMIT) begin
         if (stage_ff.pending_overflowed) begin
            // Fatal overflow: send nothing, leave the state alone
            result_in.channel_drop = 1'b1;
         end else begin
            // Resend while the peer acknowledged past our last reliable
            // packet without flipping its acked bit to ours.
            send_rel = (in_ack_ff > last_rel_seq_ff) &&
                       (in_rel_acked_ff != out_rel_bit_ff);
            // Take over the pending message when the buffer is empty
            if (rel_bytes_ff == '0 && stage_ff.pending_length != '0) begin
               rel_bytes_in   = stage_ff.pending_length;
               out_rel_bit_in = !out_rel_bit_ff;
               send_rel       = 1'b1;
               taken          = 1'b1;
            end

            result_in.hdr_word_one = {send_rel, out_seq_ff};
            result_in.hdr_word_two = {in_rel_bit_ff, in_seq_ff};
            out_seq_in = out_seq_ff + SEQ_W'(1);

            size = is_client_ff ? SIZE_W'(HDR_BYTES + PORT_BYTES) : SIZE_W'(HDR_BYTES);
            if (send_rel) begin
               size            = size + SIZE_W'(rel_bytes_in);
               last_rel_seq_in = out_seq_in;
            end
            room = SIZE_W'(MAX_SIZE) - size;
            if (size <= SIZE_W'(MAX_SIZE) && room >= SIZE_W'(stage_ff.unreliable_length)) begin
               size = size + SIZE_W'(stage_ff.unreliable_length);
               uinc = 1'b1;
            end
            bytes = size[BYTES_W-1:0];

            // Choke advance: bytes times Q16 rate, fraction dropped
            prod  = PROD_W'(bytes) * PROD_W'(rate_ff);
            delta = prod[FRAC_W +: WORD_W];
            if (choke_ff < stage_ff.now_ms) begin
               choke_in = stage_ff.now_ms + delta;
            end else begin
               choke_in = choke_ff + delta;
            end

            result_in.packet_sent         = 1'b1;
            result_in.reliable_included   = send_rel;
            result_in.pending_taken       = taken;
            result_in.unreliable_included = uinc;
            result_in.packet_bytes        = bytes;
         end
      end else begin
         // Drop stale or repeated sequence numbers
         if (rx_seq > in_seq_ff) begin
            if (stage_ff.rx_ack_word[WORD_W-1] == out_rel_bit_ff) begin
               rel_bytes_in = '0;
            end
            in_seq_in       = rx_seq;
            in_ack_in       = stage_ff.rx_ack_word[SEQ_W-1:0];
            in_rel_acked_in = stage_ff.rx_ack_word[WORD_W-1];
            if (stage_ff.rx_seq_word[WORD_W-1]) begin
               in_rel_bit_in = !in_rel_bit_ff;
            end
            result_in.rx_accepted = 1'b1;
         end
      end

      // Bandwidth status seen after this item
      result_in.can_packet   = choke_in < stage_ff.now_ms;
      result_in.can_reliable = (rel_bytes_in == '0) && result_in.can_packet;
   end

   // Commit state when the held item moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_seq_ff      <= '0;
         in_seq_ff       <= '0;
         in_ack_ff       <= '0;
         in_rel_acked_ff <= 1'b0;
         in_rel_bit_ff   <= 1'b0;
         out_rel_bit_ff  <= 1'b0;
         last_rel_seq_ff <= '0;
         rel_bytes_ff    <= '0;
         choke_ff        <= '0;
      end else if (advance) begin
         out_seq_ff      <= out_seq_in;
         in_seq_ff       <= in_seq_in;
         in_ack_ff       <= in_ack_in;
         in_rel_acked_ff <= in_rel_acked_in;
         in_rel_bit_ff   <= in_rel_bit_in;
         out_rel_bit_ff  <= out_rel_bit_in;
         last_rel_seq_ff <= last_rel_seq_in;
         rel_bytes_ff    <= rel_bytes_in;
         choke_ff        <= choke_in;
      end
   end

   // Result register: hold while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_hdr_word_one        = rsp_ff.hdr_word_one;
   assign rsp_hdr_word_two        = rsp_ff.hdr_word_two;
   assign rsp_packet_sent         = rsp_ff.packet_sent;
   assign rsp_reliable_included   = rsp_ff.reliable_included;
   assign rsp_pending_taken       = rsp_ff.pending_taken;
   assign rsp_unreliable_included = rsp_ff.unreliable_included;
   assign rsp_packet_bytes        = rsp_ff.packet_bytes;
   assign rsp_channel_drop        = rsp_ff.channel_drop;
   assign rsp_rx_accepted         = rsp_ff.rx_accepted;
   assign rsp_can_packet          = rsp_ff.can_packet;
   assign rsp_can_reliable        = rsp_ff.can_reliable;

endmodule

### design/rsch_checker.sv
// Checker: port-level assertions on the channel header block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rsch_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [rsch_pkg::WORD_W-1:0]         rsp_hdr_word_one,
   input logic                                rsp_packet_sent,
   input logic                                rsp_reliable_included,
   input logic                                rsp_pending_taken,
   input logic [rsch_pkg::BYTES_W-1:0]        rsp_packet_bytes,
   input logic                                rsp_channel_drop,
   input logic                                rsp_can_packet,
   input logic                                rsp_can_reliable
);
   import rsch_pkg::*;

   logic                        stalled;
   logic [BYTES_W+WORD_W-1:0]   shown;
   logic                        drop_fields_zero;
   logic                        take_flagged;

   assign stalled          = rsp_valid && !rsp_ready;
   assign shown            = {rsp_packet_bytes, rsp_hdr_word_one};
   assign drop_fields_zero = !rsp_packet_sent && rsp_packet_bytes == '0 &&
                             rsp_hdr_word_one == '0;
   assign take_flagged     = rsp_packet_sent && rsp_reliable_included &&
                             rsp_hdr_word_one[WORD_W-1];

   // Hold a stalled result
   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, stalled, $stable(shown))
   // A reliable slot implies the choke is clear
   `ASSERT_IMPLY(a_rel_needs_choke, clock, reset, rsp_valid && rsp_can_reliable, rsp_can_packet)
   // A dropped channel sends no packet
   `ASSERT_IMPLY(a_drop_quiet, clock, reset, rsp_valid && rsp_channel_drop, drop_fields_zero)
   // A taken message goes out at once, flagged in the header
   `ASSERT_IMPLY(a_take_sends, clock, reset, rsp_valid && rsp_pending_taken, take_flagged)

endmodule

bind reliable_seq_channel_header_top rsch_checker u_rsch_checker (.*);

### tb/channel_header_checker.sv
// Channel header checker: predicts every result of the block and compares it.
`timescale 1ns / 1ps
module channel_header_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [rsch_pkg::WORD_W-1:0]    req_now_ms,
   input  logic [rsch_pkg::LEN_W-1:0]     req_pending_length,
   input  logic                           req_pending_overflowed,
   input  logic [rsch_pkg::LEN_W-1:0]     req_unreliable_length,
   input  logic [rsch_pkg::WORD_W-1:0]    req_rx_seq_word,
   input  logic [rsch_pkg::WORD_W-1:0]    req_rx_ack_word,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [rsch_pkg::WORD_W-1:0]    rsp_hdr_word_one,
   input  logic [rsch_pkg::WORD_W-1:0]    rsp_hdr_word_two,
   input  logic                           rsp_packet_sent,
   input  logic                           rsp_reliable_included,
   input  logic                           rsp_pending_taken,
   input  logic                           rsp_unreliable_included,
   input  logic [rsch_pkg::BYTES_W-1:0]   rsp_packet_bytes,
   input  logic                           rsp_channel_drop,
   input  logic                           rsp_rx_accepted,
   input  logic                           rsp_can_packet,
   input  logic                           rsp_can_reliable,
   input  logic                           csr_we,
   input  logic [rsch_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rsch_pkg::WORD_W-1:0]    csr_wdata,
   output int                             mismatch_count,
   output int                             awaiting_results
);
   import rsch_pkg::*;

   localparam int MAX_REPORTS = 10;

   // register copies
   logic [WORD_W-1:0] rate_q16;
   logic              client_mode;

   // channel state
   logic [SEQ_W-1:0]  tx_seq;
   logic [SEQ_W-1:0]  rx_seq;
   logic [SEQ_W-1:0]  rx_ack;
   logic              rx_ack_bit;
   logic              rx_rel_bit;
   logic              tx_rel_bit;
   logic [WORD_W-1:0] rel_sent_at;
   logic [LEN_W-1:0]  rel_len;
   logic [WORD_W-1:0] choke_until;

   result_type headers_due[$];
   int         errors = 0;
   int         results_seen = 0;

   assign mismatch_count = errors;

   function automatic result_type next_header(input request_type item);
      result_type        res;
      logic              resend;
      logic [31:0]       size;
      logic [63:0]       product;
      logic [WORD_W-1:0] delta;
      res = '0;
      if (item.cmd == CMD_TRANSMIT && item.pending_overflowed) begin
         res.channel_drop = 1'b1;
      end else if (item.cmd == CMD_TRANSMIT) begin
         // resend while the peer acked past our last reliable send with the old bit
         resend = ({1'b0, rx_ack} > rel_sent_at) && (rx_ack_bit != tx_rel_bit);
         if (rel_len == '0 && item.pending_length != '0) begin
            rel_len = item.pending_length;
            tx_rel_bit = ~tx_rel_bit;
            resend = 1'b1;
            res.pending_taken = 1'b1;
         end
         res.hdr_word_one = {resend, tx_seq};
         res.hdr_word_two = {rx_rel_bit, rx_seq};
         tx_seq = tx_seq + 1'b1;
         size = HDR_BYTES + (client_mode ? PORT_BYTES : 0);
         if (resend) begin
            size = size + 32'(rel_len);
            rel_sent_at = {1'b0, tx_seq};
         end
         if (size <= MAX_SIZE && MAX_SIZE - size >= 32'(item.unreliable_length)) begin
            size = size + 32'(item.unreliable_length);
            res.unreliable_included = 1'b1;
         end
         product = 64'(size[BYTES_W-1:0]) * 64'(rate_q16);
         delta = product[FRAC_W +: WORD_W];
         choke_until = (choke_until < item.now_ms) ? item.now_ms + delta
                                                   : choke_until + delta;
         res.packet_sent = 1'b1;
         res.reliable_included = resend;
         res.packet_bytes = size[BYTES_W-1:0];
      end else if (item.rx_seq_word[SEQ_W-1:0] > rx_seq) begin
         if (item.rx_ack_word[WORD_W-1] == tx_rel_bit) rel_len = '0;
         rx_seq = item.rx_seq_word[SEQ_W-1:0];
         rx_ack = item.rx_ack_word[SEQ_W-1:0];
         rx_ack_bit = item.rx_ack_word[WORD_W-1];
         if (item.rx_seq_word[WORD_W-1]) rx_rel_bit = ~rx_rel_bit;
         res.rx_accepted = 1'b1;
      end
      res.can_packet = choke_until < item.now_ms;
      res.can_reliable = (rel_len == '0) && res.can_packet;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         if (errors < MAX_REPORTS)
            $display("%0t: result %0d %s expected %h got %h",
                     $time, results_seen, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      request_type item;
      result_type  want;
      if (reset) begin
         rate_q16 = RATE_RESET;
         client_mode = 1'b0;
         tx_seq = '0;
         rx_seq = '0;
         rx_ack = '0;
         rx_ack_bit = 1'b0;
         rx_rel_bit = 1'b0;
         tx_rel_bit = 1'b0;
         rel_sent_at = '0;
         rel_len = '0;
         choke_until = '0;
         headers_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RATE:        rate_q16 = csr_wdata;
               CSR_IS_CLIENT:   client_mode = csr_wdata[0];
               CSR_CLIENT_PORT: ;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (headers_due.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("%0t: result %0d arrived with nothing outstanding",
                           $time, results_seen);
               errors++;
            end else begin
               want = headers_due.pop_front();
               check_field("hdr_word_one", want.hdr_word_one, rsp_hdr_word_one);
               check_field("hdr_word_two", want.hdr_word_two, rsp_hdr_word_two);
               check_field("packet_sent", WORD_W'(want.packet_sent),
                           WORD_W'(rsp_packet_sent));
               check_field("reliable_included", WORD_W'(want.reliable_included),
                           WORD_W'(rsp_reliable_included));
               check_field("pending_taken", WORD_W'(want.pending_taken),
                           WORD_W'(rsp_pending_taken));
               check_field("unreliable_included", WORD_W'(want.unreliable_included),
                           WORD_W'(rsp_unreliable_included));
               check_field("packet_bytes", WORD_W'(want.packet_bytes),
                           WORD_W'(rsp_packet_bytes));
               check_field("channel_drop", WORD_W'(want.channel_drop),
                           WORD_W'(rsp_channel_drop));
               check_field("rx_accepted", WORD_W'(want.rx_accepted),
                           WORD_W'(rsp_rx_accepted));
               check_field("can_packet", WORD_W'(want.can_packet),
                           WORD_W'(rsp_can_packet));
               check_field("can_reliable", WORD_W'(want.can_reliable),
                           WORD_W'(rsp_can_reliable));
            end
         end
         if (req_valid && req_ready) begin
            item.cmd = cmd_type'(req_cmd);
            item.now_ms = req_now_ms;
            item.pending_length = req_pending_length;
            item.pending_overflowed = req_pending_overflowed;
            item.unreliable_length = req_unreliable_length;
            item.rx_seq_word = req_rx_seq_word;
            item.rx_ack_word = req_rx_ack_word;
            headers_due.push_back(next_header(item));
         end
      end
      awaiting_results <= headers_due.size();
   end

endmodule

### tb/reliable_seq_channel_header_top_test.sv
// Testbench top: drives the channel header block, then reports the verdict.
`timescale 1ns / 1ps
module reliable_seq_channel_header_top_test;
   import rsch_pkg::*;

   // Receiver hold-off long enough to back the pipeline up into the input.
   localparam int HOLD_CYCLES = 200;
   // Cycles with no item moving on either channel before the run is abandoned;
   // well above one hold-off plus the longest sender gap and receiver stall.
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 375;
   localparam int PHASES      = 5;
   localparam int LEN_MAX     = (1 << LEN_W) - 1;
   localparam logic [LEN_W-1:0] LEN_ALL     = '1;
   localparam logic [LEN_W-1:0] PAYLOAD_LEN = LEN_W'(MAX_PAYLOAD);

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_cmd;
   logic [WORD_W-1:0]    req_now_ms;
   logic [LEN_W-1:0]     req_pending_length;
   logic                 req_pending_overflowed;
   logic [LEN_W-1:0]     req_unreliable_length;
   logic [WORD_W-1:0]    req_rx_seq_word;
   logic [WORD_W-1:0]    req_rx_ack_word;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [WORD_W-1:0]    rsp_hdr_word_one;
   logic [WORD_W-1:0]    rsp_hdr_word_two;
   logic                 rsp_packet_sent;
   logic                 rsp_reliable_included;
   logic                 rsp_pending_taken;
   logic                 rsp_unreliable_included;
   logic [BYTES_W-1:0]   rsp_packet_bytes;
   logic                 rsp_channel_drop;
   logic                 rsp_rx_accepted;
   logic                 rsp_can_packet;
   logic                 rsp_can_reliable;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   int mismatch_count;
   int awaiting_results;
   int idle_cycles = 0;

   // Shared pacing controls: no_gaps turns off idling on both sides,
   // hold_responses asks the receiver for one long hold-off.
   bit no_gaps;
   bit hold_responses;

   // Stimulus bookkeeping, only used to shape well-formed traffic:
   // packets sent so far (acks aim near it) and the newest peer sequence.
   logic [SEQ_W-1:0]  sent_packets;
   logic [SEQ_W-1:0]  peer_seq;
   logic [WORD_W-1:0] sim_ms;

   reliable_seq_channel_header_top uut (.*);
   channel_header_checker hdr_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: count cycles where nothing is accepted on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: stall a random number of cycles per item, then hold ready
   // high until a result is taken. One long hold-off when asked.
   initial begin : receiver
      int stall;
      rsp_ready = 1'b0;
      forever begin
         if (hold_responses) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_responses = 1'b0;
         end
         stall = no_gaps ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Build a transmit item; the receive-only fields carry random junk.
   function automatic request_type transmit_item(input logic [WORD_W-1:0] now,
                                                 input logic [LEN_W-1:0] pend,
                                                 input logic ovf,
                                                 input logic [LEN_W-1:0] ulen);
      request_type item;
      item.cmd = CMD_TRANSMIT;
      item.now_ms = now;
      item.pending_length = pend;
      item.pending_overflowed = ovf;
      item.unreliable_length = ulen;
      item.rx_seq_word = $urandom();
      item.rx_ack_word = $urandom();
      return item;
   endfunction

   // Build a receive item; the transmit-only fields carry random junk.
   function automatic request_type receive_item(input logic [WORD_W-1:0] now,
                                                input logic [WORD_W-1:0] seq_word,
                                                input logic [WORD_W-1:0] ack_word);
      request_type item;
      item.cmd = CMD_RECEIVE;
      item.now_ms = now;
      item.pending_length = LEN_W'($urandom_range(0, LEN_MAX));
      item.pending_overflowed = 1'($urandom_range(0, 1));
      item.unreliable_length = LEN_W'($urandom_range(0, LEN_MAX));
      item.rx_seq_word = seq_word;
      item.rx_ack_word = ack_word;
      return item;
   endfunction

   // Offer one item after a random gap and hold it until accepted.
   task automatic offer_item(input request_type item);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= item.cmd;
      req_now_ms <= item.now_ms;
      req_pending_length <= item.pending_length;
      req_pending_overflowed <= item.pending_overflowed;
      req_unreliable_length <= item.unreliable_length;
      req_rx_seq_word <= item.rx_seq_word;
      req_rx_ack_word <= item.rx_ack_word;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (item.cmd == CMD_TRANSMIT && !item.pending_overflowed)
         sent_packets = sent_packets + 1'b1;
      else if (item.cmd == CMD_RECEIVE && item.rx_seq_word[SEQ_W-1:0] > peer_seq)
         peer_seq = item.rx_seq_word[SEQ_W-1:0];
   endtask

   // Drop valid and wait until every outstanding result has come back.
   task automatic settle_channel();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting_results != 0);
   endtask

   // Write all three registers on consecutive edges; block must be idle.
   task automatic load_settings(input logic [WORD_W-1:0] rate, input logic client,
                                input logic [15:0] port);
      csr_we <= 1'b1;
      csr_index <= CSR_RATE;
      csr_wdata <= rate;
      @(posedge clock);
      csr_index <= CSR_IS_CLIENT;
      csr_wdata <= WORD_W'(client);
      @(posedge clock);
      csr_index <= CSR_CLIENT_PORT;
      csr_wdata <= WORD_W'(port);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Random traffic: mostly a well-behaved peer exchanging reliable
   // messages, with stale and junk headers and overflows mixed in.
   task automatic random_phase(input int count, input bit start_eager);
      request_type      item;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] ack;
      logic [LEN_W-1:0] pend;
      logic [LEN_W-1:0] ulen;
      logic             rel_flag;
      logic             ack_flag;
      int               pick;
      for (int i = 0; i < count; i++) begin
         // alternate idling with stretches of back-to-back traffic
         if (i % 50 == 0) no_gaps = (i == 0) ? start_eager : ($urandom_range(0, 3) == 0);
         // advance time slowly, with the odd jump anywhere in the 32-bit range
         if ($urandom_range(0, 49) == 0) sim_ms = $urandom();
         else sim_ms = sim_ms + $urandom_range(0, 40);
         rel_flag = 1'($urandom_range(0, 1));
         ack_flag = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 55) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) pend = '0;
            else if (pick < 8) pend = LEN_W'($urandom_range(1, 300));
            else if (pick == 8) pend = LEN_W'($urandom_range(0, LEN_MAX));
            else pend = LEN_W'($urandom_range(MAX_PAYLOAD - 92, MAX_PAYLOAD + 8));
            pick = $urandom_range(0, 9);
            if (pick < 6) ulen = LEN_W'($urandom_range(0, 200));
            else if (pick < 8)
               ulen = LEN_W'($urandom_range(MAX_PAYLOAD - 300, MAX_PAYLOAD + 8));
            else ulen = LEN_W'($urandom_range(0, LEN_MAX));
            item = transmit_item(sim_ms, pend, $urandom_range(0, 99) < 3, ulen);
         end else begin
            pick = $urandom_range(0, 9);
            seq = SEQ_W'(peer_seq + $urandom_range(1, 3));
            ack = SEQ_W'(sent_packets - $urandom_range(0, 2));
            if (pick < 8) begin
               item = receive_item(sim_ms, {rel_flag, seq}, {ack_flag, ack});
            end else if (pick == 8) begin
               // stale: at or below the newest sequence already accepted
               seq = SEQ_W'(peer_seq -
                            $urandom_range(0, (peer_seq < 1000) ? peer_seq : 1000));
               item = receive_item(sim_ms, {rel_flag, seq}, $urandom());
            end else begin
               item = receive_item(sim_ms, {rel_flag, seq}, $urandom());
            end
         end
         offer_item(item);
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_TRANSMIT;
      req_now_ms = '0;
      req_pending_length = '0;
      req_pending_overflowed = 1'b0;
      req_unreliable_length = '0;
      req_rx_seq_word = '0;
      req_rx_ack_word = '0;
      csr_we = 1'b0;
      csr_index = CSR_RATE;
      csr_wdata = '0;
      no_gaps = 1'b0;
      hold_responses = 1'b0;
      sent_packets = '0;
      peer_seq = '0;
      sim_ms = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed walk with reset settings: plain send, overflow, takeover of
      // a full-width pending message, busy buffer, stale and fresh headers,
      // a resend after an ack with the old bit, clears on a matching ack,
      // exact and one-over unreliable room, and time at both ends.
      offer_item(transmit_item(32'd0, '0, 1'b0, '0));
      offer_item(transmit_item(32'd5, LEN_ALL, 1'b1, LEN_ALL));
      offer_item(transmit_item(32'd10, LEN_ALL, 1'b0, LEN_ALL));
      offer_item(transmit_item(32'd11, 14'd5, 1'b0, 14'd100));
      offer_item(receive_item(32'd20, 32'h8000_0001, 32'h0000_0000));
      offer_item(receive_item(32'd21, 32'h0000_0001, 32'h8000_0005));
      offer_item(receive_item(32'd22, 32'h0000_0002, 32'h0000_0003));
      offer_item(transmit_item(32'd23, '0, 1'b0, PAYLOAD_LEN));
      offer_item(receive_item(32'd30, 32'h0000_0003, 32'h8000_0004));
      offer_item(transmit_item(32'd40, PAYLOAD_LEN, 1'b0, '0));
      offer_item(receive_item(32'd50, 32'h8000_0004, 32'h0000_0005));
      offer_item(transmit_item(32'd60, '0, 1'b0, PAYLOAD_LEN));
      offer_item(transmit_item(32'd61, '0, 1'b0, PAYLOAD_LEN + 14'd1));
      offer_item(transmit_item(32'hFFFF_FFFF, 14'd1, 1'b0, '0));
      sim_ms = 32'd100;

      for (int p = 0; p < PHASES; p++) begin
         settle_channel();
         case (p)
            0: load_settings('0, 1'b0, '0);
            1: load_settings('1, 1'b1, '1);
            2: load_settings(RATE_RESET, 1'b1, 16'h5A5A);
            3: load_settings(32'h0001_0000, 1'b0, '0);
            default: load_settings($urandom(), 1'b1, 16'($urandom()));
         endcase
         if (p == 1) begin
            // client header at the top rate: choke time wraps, and the port
            // field shifts the unreliable room by two bytes
            offer_item(transmit_item(32'hFFFF_FFF0, LEN_ALL, 1'b0, '0));
            offer_item(transmit_item(32'hFFFF_FFF8, '0, 1'b0, PAYLOAD_LEN - 14'd2));
            offer_item(transmit_item(32'hFFFF_FFFF, '0, 1'b0, PAYLOAD_LEN - 14'd1));
            sim_ms = 32'hFFFF_FF00;
         end
         // back the block up behind a long receiver hold-off
         if (p == 2) hold_responses = 1'b1;
         random_phase(PHASE_ITEMS, p == 2 || p == 4);
      end

      // Close with the largest sequence number, which freezes the receive
      // side, then a repeat of it that must be stale.
      settle_channel();
      no_gaps = 1'b0;
      offer_item(receive_item(sim_ms, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      offer_item(receive_item(sim_ms + 32'd1, 32'hFFFF_FFFF, 32'h0000_0000));
      offer_item(transmit_item(sim_ms + 32'd2, '0, 1'b0, '0));

      settle_channel();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && awaiting_results == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/rsch_pkg.sv
design/reliable_seq_channel_header_top.sv
design/rsch_checker.sv
tb/channel_header_checker.sv
tb/reliable_seq_channel_header_top_test.sv
